// ----- hw/rtl/ascii_number_frame_parser_macros.svh -----
// assertion macros shared by the frame parser modules
// each use expects clk and rst_n in scope
`ifndef ASCII_NUMBER_FRAME_PARSER_MACROS_SVH
`define ASCII_NUMBER_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define ANFP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// when the trigger holds, the condition must hold at the next clock edge
`define ANFP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define ANFP_ASSERT(label, cond, msg)
`define ANFP_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

// ----- hw/rtl/anfp_pkg.sv -----
package anfp_pkg;

    // byte codes the parser reacts to
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // acknowledge values saturate here
    localparam logic [7:0] ACK_MAX = 8'hFF;

    // frame kinds as reported on the result
    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // byte class worked out by the front end
    typedef enum logic [3:0] {
        CLS_AT,
        CLS_CARET,
        CLS_CR,
        CLS_LF,
        CLS_DIGIT,
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DOT,
        CLS_OTHER
    } class_t;

    // classified beat held in the queue
    typedef struct packed {
        class_t     cls;
        logic [3:0] digit;
    } beat_t;

endpackage

// ----- hw/rtl/anfp_front.sv -----
module anfp_front (
    input  logic [7:0]      rx_byte,
    output anfp_pkg::beat_t beat
);

    // sort the byte into the classes the parser acts on
    always_comb
    begin
        beat.digit = rx_byte[3:0];
        priority if (rx_byte == anfp_pkg::CH_AT)
            beat.cls = anfp_pkg::CLS_AT;
        else if (rx_byte == anfp_pkg::CH_CARET)
            beat.cls = anfp_pkg::CLS_CARET;
        else if (rx_byte == anfp_pkg::CH_CR)
            beat.cls = anfp_pkg::CLS_CR;
        else if (rx_byte == anfp_pkg::CH_LF)
            beat.cls = anfp_pkg::CLS_LF;
        else if (rx_byte >= anfp_pkg::CH_ZERO && rx_byte <= anfp_pkg::CH_NINE)
            beat.cls = anfp_pkg::CLS_DIGIT;
        else if (rx_byte == anfp_pkg::CH_SPACE || rx_byte == anfp_pkg::CH_TAB
                 || rx_byte == anfp_pkg::CH_VT || rx_byte == anfp_pkg::CH_FF)
            beat.cls = anfp_pkg::CLS_BLANK;
        else if (rx_byte == anfp_pkg::CH_PLUS)
            beat.cls = anfp_pkg::CLS_PLUS;
        else if (rx_byte == anfp_pkg::CH_MINUS)
            beat.cls = anfp_pkg::CLS_MINUS;
        else if (rx_byte == anfp_pkg::CH_DOT)
            beat.cls = anfp_pkg::CLS_DOT;
        else
            beat.cls = anfp_pkg::CLS_OTHER;
    end

endmodule

// ----- hw/rtl/anfp_queue.sv -----
`include "ascii_number_frame_parser_macros.svh"

module anfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  anfp_pkg::beat_t push_beat,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output anfp_pkg::beat_t pop_beat
);

    localparam int DEPTH = 2;

    anfp_pkg::beat_t mem_reg [DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = (count_reg == 2'(DEPTH));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_beat  = mem_reg[rd_ptr_reg];

    // storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    `ANFP_ASSERT(a_count_bound, count_reg <= 2'(DEPTH), "queue fill count beyond depth")
    `ANFP_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 2'd1, "lost push")
    `ANFP_ASSERT(a_pop_nonempty, !pop || count_reg != 2'd0, "queue popped while empty")

endmodule

// ----- hw/rtl/anfp_back.sv -----
`include "ascii_number_frame_parser_macros.svh"

module anfp_back #(
    parameter int MAX_FRAME_LEN = 100,
    parameter int VALUE_BITS    = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  anfp_pkg::beat_t q_beat,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            frame_done,
    output logic            frame_kind,
    output logic [15:0]     first_value,
    output logic [15:0]     second_value,
    output logic [7:0]      ack_value
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int ACC_W = VALUE_BITS + 4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_WAIT_LF
    } phase_t;

    phase_t                phase_reg,       phase_next;
    logic                  type_reg,        type_next;
    logic [1:0]            fidx_reg,        fidx_next;
    logic [VALUE_BITS-1:0] acc1_reg,        acc1_next;
    logic [VALUE_BITS-1:0] acc2_reg,        acc2_next;
    logic [1:0]            dflags_reg,      dflags_next;
    logic                  sign_reg,        sign_next;
    logic [1:0]            neg_reg,         neg_next;
    logic                  broken_reg,      broken_next;
    logic [CNT_W-1:0]      count_reg,       count_next;
    logic [VALUE_BITS-1:0] held_first_reg,  held_first_next;
    logic [VALUE_BITS-1:0] held_second_reg, held_second_next;
    logic [7:0]            held_ack_reg,    held_ack_next;
    logic                  out_valid_reg,   out_valid_next;
    logic                  out_done_reg,    out_done_next;
    logic                  out_kind_reg,    out_kind_next;

    logic                  pop;
    logic [1:0]            field_bit;
    logic                  have_digit;
    logic                  is_blank;
    logic [ACC_W-1:0]      acc_ext;
    logic [ACC_W-1:0]      acc_prod;
    logic [VALUE_BITS-1:0] acc_sat;
    logic [7:0]            ack_sat;
    logic [VALUE_BITS+15:0] first_ext;
    logic [VALUE_BITS+15:0] second_ext;

    // take a beat whenever the result slot is free or being drained
    assign pop   = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = pop;

    // digit accumulate with saturation at the value range
    assign acc_ext  = {4'd0, (fidx_reg == 2'd0) ? acc1_reg : acc2_reg};
    assign acc_prod = (acc_ext << 3) + (acc_ext << 1)
                    + {{VALUE_BITS{1'b0}}, q_beat.digit};
    assign acc_sat  = (|acc_prod[ACC_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                      : acc_prod[VALUE_BITS-1:0];

    // acknowledge value clipped to a byte
    assign ack_sat = (acc1_reg > VALUE_BITS'(anfp_pkg::ACK_MAX)) ? anfp_pkg::ACK_MAX
                                                                 : acc1_reg[7:0];

    assign field_bit  = (fidx_reg == 2'd0) ? 2'b01 : 2'b10;
    assign have_digit = |(dflags_reg & field_bit);
    assign is_blank   = (q_beat.cls == anfp_pkg::CLS_BLANK)
                     || (q_beat.cls == anfp_pkg::CLS_LF);

    // parser step for one beat
    always_comb
    begin
        phase_next       = phase_reg;
        type_next        = type_reg;
        fidx_next        = fidx_reg;
        acc1_next        = acc1_reg;
        acc2_next        = acc2_reg;
        dflags_next      = dflags_reg;
        sign_next        = sign_reg;
        neg_next         = neg_reg;
        broken_next      = broken_reg;
        count_next       = count_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        held_ack_next    = held_ack_reg;
        out_done_next    = out_done_reg;
        out_kind_next    = out_kind_reg;
        out_valid_next   = out_valid_reg && out_stall;

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_done_next  = 1'b0;
            out_kind_next  = anfp_pkg::KIND_PAIR;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_beat.cls == anfp_pkg::CLS_AT || q_beat.cls == anfp_pkg::CLS_CARET)
                    begin
                        phase_next  = PH_BODY;
                        type_next   = (q_beat.cls == anfp_pkg::CLS_CARET) ? anfp_pkg::KIND_ACK
                                                                          : anfp_pkg::KIND_PAIR;
                        fidx_next   = 2'd0;
                        acc1_next   = '0;
                        acc2_next   = '0;
                        dflags_next = 2'b00;
                        sign_next   = 1'b0;
                        neg_next    = 2'b00;
                        broken_next = 1'b0;
                        count_next  = '0;
                    end
                end
                PH_BODY:
                begin
                    if (q_beat.cls == anfp_pkg::CLS_CR)
                    begin
                        phase_next = PH_WAIT_LF;
                    end
                    else if (count_reg < CNT_W'(MAX_FRAME_LEN))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (!broken_reg && fidx_reg < 2'd2)
                        begin
                            priority if (q_beat.cls == anfp_pkg::CLS_DIGIT)
                            begin
                                if (fidx_reg == 2'd0)
                                    acc1_next = acc_sat;
                                else
                                    acc2_next = acc_sat;
                                dflags_next = dflags_reg | field_bit;
                            end
                            else if (!have_digit)
                            begin
                                // leading blanks, one sign, else the body is broken
                                priority if (!sign_reg && is_blank)
                                begin
                                    sign_next = sign_reg;
                                end
                                else if (!sign_reg && (q_beat.cls == anfp_pkg::CLS_PLUS
                                         || q_beat.cls == anfp_pkg::CLS_MINUS))
                                begin
                                    sign_next = 1'b1;
                                    if (q_beat.cls == anfp_pkg::CLS_MINUS)
                                        neg_next = neg_reg | field_bit;
                                end
                                else
                                begin
                                    broken_next = 1'b1;
                                end
                            end
                            else if (fidx_reg == 2'd0 && type_reg == anfp_pkg::KIND_PAIR
                                     && q_beat.cls == anfp_pkg::CLS_DOT)
                            begin
                                fidx_next = 2'd1;
                                sign_next = 1'b0;
                            end
                            else
                            begin
                                fidx_next = 2'd2;
                            end
                        end
                    end
                end
                PH_WAIT_LF:
                begin
                    if (q_beat.cls == anfp_pkg::CLS_LF)
                    begin
                        out_done_next = 1'b1;
                        out_kind_next = type_reg;
                        phase_next    = PH_IDLE;
                        if (type_reg == anfp_pkg::KIND_PAIR)
                        begin
                            if (dflags_reg[0])
                                held_first_next = neg_reg[0] ? '0 : acc1_reg;
                            if (dflags_reg[0] && dflags_reg[1])
                                held_second_next = neg_reg[1] ? '0 : acc2_reg;
                        end
                        else if (dflags_reg[0])
                        begin
                            held_ack_next = neg_reg[0] ? 8'd0 : ack_sat;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // parser state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            type_reg        <= 1'b0;
            fidx_reg        <= 2'd0;
            acc1_reg        <= '0;
            acc2_reg        <= '0;
            dflags_reg      <= 2'b00;
            sign_reg        <= 1'b0;
            neg_reg         <= 2'b00;
            broken_reg      <= 1'b0;
            count_reg       <= '0;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            held_ack_reg    <= 8'd0;
            out_valid_reg   <= 1'b0;
            out_done_reg    <= 1'b0;
            out_kind_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            type_reg        <= type_next;
            fidx_reg        <= fidx_next;
            acc1_reg        <= acc1_next;
            acc2_reg        <= acc2_next;
            dflags_reg      <= dflags_next;
            sign_reg        <= sign_next;
            neg_reg         <= neg_next;
            broken_reg      <= broken_next;
            count_reg       <= count_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            held_ack_reg    <= held_ack_next;
            out_valid_reg   <= out_valid_next;
            out_done_reg    <= out_done_next;
            out_kind_reg    <= out_kind_next;
        end
    end

    // held values only move on a pop, so they stand as the result payload
    assign first_ext    = {16'd0, held_first_reg};
    assign second_ext   = {16'd0, held_second_reg};
    assign out_valid    = out_valid_reg;
    assign frame_done   = out_done_reg;
    assign frame_kind   = out_kind_reg;
    assign first_value  = first_ext[15:0];
    assign second_value = second_ext[15:0];
    assign ack_value    = held_ack_reg;

    `ANFP_ASSERT(a_field_range, fidx_reg != 2'd3, "field index out of range")
    `ANFP_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_FRAME_LEN), "body count past bound")
    `ANFP_ASSERT(a_kind_needs_done, !out_kind_reg || out_done_reg, "ack kind without done")

endmodule

// ----- hw/rtl/ascii_number_frame_parser.sv -----
// Parses '@' pair frames ("n.n." CR LF) and '^' acknowledge frames ("n." CR LF) from a
// stream of received bytes, one beat per byte in and one result beat per byte out.
// Every byte gives a result: frame_done marks the LF that closed a frame and frame_kind
// tells which kind, while the value outputs always show the latest held numbers.
// The block takes one byte per clock cycle when the result side keeps up; a byte's result
// is offered once the classified byte has entered the two-entry queue at the accepting
// edge and the parser step, with its single digit multiply-accumulate, has registered the
// result as the byte leaves the queue. While the result side stalls the queue keeps taking
// beats until both entries are held: one more beat when the stream was flowing, two when
// the queue was empty.

`include "ascii_number_frame_parser_macros.svh"

module ascii_number_frame_parser #(
    parameter int MAX_FRAME_LEN = 100,
    parameter int VALUE_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_done,
    output logic        frame_kind,
    output logic [15:0] first_value,
    output logic [15:0] second_value,
    output logic [7:0]  ack_value
);

    anfp_pkg::beat_t front_beat;
    anfp_pkg::beat_t q_beat;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    // input side stalls only on a full queue
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    anfp_front u_front (
        .rx_byte (rx_byte),
        .beat    (front_beat)
    );

    anfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (front_beat),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_beat  (q_beat)
    );

    anfp_back #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_beat       (q_beat),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_done   (frame_done),
        .frame_kind   (frame_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .ack_value    (ack_value)
    );

endmodule
